>>> src/datetime_text_to_epoch_seconds_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the date-time text to epoch seconds block
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DATETIME_TEXT_TO_EPOCH_SECONDS_TOP_MACROS_SVH
`define DATETIME_TEXT_TO_EPOCH_SECONDS_TOP_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define DTEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtep assertion failed");

// next-cycle implication, masked while reset is asserted
`define DTEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtep assertion failed");

// next-cycle implication that also holds through reset
`define DTEP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dtep assertion failed");

`endif

>>> src/dtep_pkg.sv
// ----------------------------------------------------------------------------
// dtep_pkg
// Types, character positions and calendar table for the epoch converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtep_pkg;

    typedef logic [4:0] t_pos;
    typedef logic [6:0] t_two_digit;

    localparam int unsigned CFG_W = 18;

    // character positions within "yy/MM/dd,hh:mm:ss+zz"
    localparam t_pos POS_YEAR_HI   = 5'd0;
    localparam t_pos POS_YEAR_LO   = 5'd1;
    localparam t_pos POS_MONTH_HI  = 5'd3;
    localparam t_pos POS_MONTH_LO  = 5'd4;
    localparam t_pos POS_DAY_HI    = 5'd6;
    localparam t_pos POS_DAY_LO    = 5'd7;
    localparam t_pos POS_HOUR_HI   = 5'd9;
    localparam t_pos POS_HOUR_LO   = 5'd10;
    localparam t_pos POS_MINUTE_HI = 5'd12;
    localparam t_pos POS_MINUTE_LO = 5'd13;
    localparam t_pos POS_SECOND_HI = 5'd15;
    localparam t_pos POS_SECOND_LO = 5'd16;
    localparam t_pos POS_SIGN      = 5'd17;
    localparam t_pos POS_ZONE_HI   = 5'd18;
    localparam t_pos POS_ZONE_LO   = 5'd19;
    localparam t_pos POS_LAST      = 5'd19;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic signed [CFG_W-1:0] REF_OFFSET_RESET = 18'sd19800;

    localparam t_two_digit MONTH_MAX      = 7'd12;
    localparam logic [3:0] MONTH_CLAMP    = 4'd13;
    localparam logic [3:0] MONTH_FEB      = 4'd2;

    localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
    localparam logic [31:0] SECS_PER_MINUTE = 32'd60;
    localparam logic [31:0] SECS_PER_ZONE   = 32'd900;
    localparam logic [15:0] DAYS_PER_YEAR   = 16'd365;

    // days before the first of month m; 13 stands for any month past December
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // shift one decimal digit into a two-digit field, 7-bit wrap
    function automatic t_two_digit push_digit(input t_two_digit acc, input logic [3:0] d);
        logic [10:0] v;
        v = ({4'b0, acc} * 11'd10) + {7'b0, d};
        return v[6:0];
    endfunction

endpackage

`default_nettype wire

>>> src/datetime_text_to_epoch_seconds_top.sv
// ----------------------------------------------------------------------------
// datetime_text_to_epoch_seconds_top
// Modem clock text "yy/MM/dd,hh:mm:ss+zz" to Unix epoch seconds.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle; the field registers update as each
//   character is taken, so input never waits unless the result side stalls.
// Result path: once the twentieth character is taken, the word passes through
//   the field snapshot, the calendar sums and the day multiply into the output register.
// Reset (synchronous, active low): position and all fields clear, the pipeline
//   empties and the reference offset returns to 19800 seconds.
`default_nettype none

module datetime_text_to_epoch_seconds_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // character input
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [7:0]                           i_symbol,
    input  wire logic                                 i_restart,
    // result output
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [31:0]                               o_epoch_seconds,
    output logic                                      o_format_error,
    // reference offset write
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic signed [dtep_pkg::CFG_W-1:0]    i_cfg_data
);

    import dtep_pkg::*;

    // ------------------------------------------------------------------
    // Parsed fields of one string, handed from the parser to the math.
    // ------------------------------------------------------------------
    typedef struct packed {
        t_two_digit year;
        t_two_digit month;
        t_two_digit day;
        t_two_digit hour;
        t_two_digit minute;
        t_two_digit second;
        t_two_digit zone;
        logic       zone_neg;
        logic       err;
    } t_fields;

    // ------------------------------------------------------------------
    // Configuration: the offset register is writable at any time; the
    // user writes it only while no string is in flight.
    // ------------------------------------------------------------------
    logic signed [CFG_W-1:0] r_ref_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_offset <= REF_OFFSET_RESET;
        end else if (i_cfg_valid) begin
            r_ref_offset <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Stage A holds a finished field snapshot,
    // stage B the calendar sums, the output register the result word.
    // Each stage advances when the one after it is empty or draining.
    // ------------------------------------------------------------------
    logic r_a_valid;
    logic r_b_valid;
    logic r_o_valid;
    logic out_free;
    logic b_free;
    logic a_free;
    logic in_take;

    assign out_free   = !r_o_valid || i_out_ready;
    assign b_free     = !r_b_valid || out_free;
    assign a_free     = !r_a_valid || b_free;
    assign o_in_ready = a_free;
    assign in_take    = i_in_valid && a_free;

    // ------------------------------------------------------------------
    // Character parser: digit accumulate per field by position.
    // ------------------------------------------------------------------
    t_pos    r_pos;
    t_fields r_acc;
    t_pos    n_pos;
    t_fields n_acc;
    t_pos    pos;
    logic    is_digit;
    logic [3:0] digit;
    logic    last_char;

    always_comb begin
        // restart abandons a partial string; out-of-range positions fold to 0
        pos = i_restart ? POS_YEAR_HI : r_pos;
        if (pos > POS_LAST) begin
            pos = POS_YEAR_HI;
        end

        is_digit = i_symbol inside {[8'h30:8'h39]};
        digit    = is_digit ? i_symbol[3:0] : 4'd0;

        // a new string starts from cleared fields
        n_acc = (pos == POS_YEAR_HI) ? '0 : r_acc;

        case (pos)
            POS_YEAR_HI, POS_YEAR_LO: begin
                n_acc.year = push_digit(n_acc.year, digit);
                n_acc.err  = n_acc.err || !is_digit;
            end
            POS_MONTH_HI, POS_MONTH_LO: begin
                n_acc.month = push_digit(n_acc.month, digit);
                n_acc.err   = n_acc.err || !is_digit;
            end
            POS_DAY_HI, POS_DAY_LO: begin
                n_acc.day = push_digit(n_acc.day, digit);
                n_acc.err = n_acc.err || !is_digit;
            end
            POS_HOUR_HI, POS_HOUR_LO: begin
                n_acc.hour = push_digit(n_acc.hour, digit);
                n_acc.err  = n_acc.err || !is_digit;
            end
            POS_MINUTE_HI, POS_MINUTE_LO: begin
                n_acc.minute = push_digit(n_acc.minute, digit);
                n_acc.err    = n_acc.err || !is_digit;
            end
            POS_SECOND_HI, POS_SECOND_LO: begin
                n_acc.second = push_digit(n_acc.second, digit);
                n_acc.err    = n_acc.err || !is_digit;
            end
            POS_SIGN: begin
                // anything but a minus reads as a positive zone
                n_acc.zone_neg = (i_symbol == CHAR_MINUS);
            end
            POS_ZONE_HI, POS_ZONE_LO: begin
                n_acc.zone = push_digit(n_acc.zone, digit);
                n_acc.err  = n_acc.err || !is_digit;
            end
            default: begin
                // separator: ignore the character
            end
        endcase

        last_char = (pos == POS_LAST);
        n_pos     = last_char ? POS_YEAR_HI : pos + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_acc <= '0;
        end else if (in_take) begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: snapshot the complete fields on the last character, and
    // fold the month-range check into the error flag.
    // ------------------------------------------------------------------
    t_fields r_a;
    t_fields n_a;

    always_comb begin
        n_a     = n_acc;
        n_a.err = n_acc.err || (n_acc.month > MONTH_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take && last_char) begin
            r_a_valid <= 1'b1;
        end else if (b_free) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && last_char) begin
            r_a <= n_a;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: day count since 1970 and the seconds-of-day plus offset
    // and zone correction. Day count stays within 16 bits for 2000..2099.
    // ------------------------------------------------------------------
    logic [15:0] r_b_days;
    logic [31:0] r_b_rest;
    logic        r_b_err;
    logic [15:0] n_b_days;
    logic [31:0] n_b_rest;
    logic [7:0]  year_30;
    logic [7:0]  year_31;
    logic [3:0]  month_idx;
    logic        leap_add;
    logic [31:0] zone_secs;
    logic [31:0] zone_adj;
    logic [31:0] offset_ext;

    always_comb begin
        year_30   = {1'b0, r_a.year} + 8'd30;
        year_31   = {1'b0, r_a.year} + 8'd31;
        month_idx = (r_a.month > 7'd13) ? MONTH_CLAMP : r_a.month[3:0];
        leap_add  = (r_a.year[1:0] == 2'b00) && (month_idx > MONTH_FEB);

        n_b_days = ({8'b0, year_30} * DAYS_PER_YEAR)
                 + {10'b0, year_31[7:2]}
                 + {7'b0, days_before_month(month_idx)}
                 + {15'b0, leap_add}
                 + {9'b0, r_a.day}
                 - 16'd1;

        zone_secs  = {25'b0, r_a.zone} * SECS_PER_ZONE;
        zone_adj   = r_a.zone_neg ? zone_secs : (32'd0 - zone_secs);
        offset_ext = {{(32 - CFG_W){r_ref_offset[CFG_W-1]}}, r_ref_offset};

        n_b_rest = ({25'b0, r_a.hour} * SECS_PER_HOUR)
                 + ({25'b0, r_a.minute} * SECS_PER_MINUTE)
                 + {25'b0, r_a.second}
                 + offset_ext
                 + zone_adj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && b_free) begin
            r_b_days <= n_b_days;
            r_b_rest <= n_b_rest;
            r_b_err  <= r_a.err;
        end
    end

    // ------------------------------------------------------------------
    // Output register: scale days to seconds and add the rest, mod 2^32.
    // Hold the word until the consumer takes it.
    // ------------------------------------------------------------------
    logic [31:0] r_epoch;
    logic        r_err;
    logic [31:0] n_epoch;

    assign n_epoch = ({16'b0, r_b_days} * SECS_PER_DAY) + r_b_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && out_free) begin
            r_epoch <= n_epoch;
            r_err   <= r_b_err;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_epoch_seconds = r_epoch;
    assign o_format_error  = r_err;

endmodule

`default_nettype wire

>>> src/dtep_checker.sv
// ----------------------------------------------------------------------------
// dtep_checker
// Port-level checks for the epoch converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "datetime_text_to_epoch_seconds_top_macros.svh"

module dtep_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [31:0]                        o_epoch_seconds,
    input wire logic                               o_format_error
);

    // reset empties the result register
    `DTEP_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

    // a fresh result trails the closing character word by the result pipeline
    `DTEP_ASSERT_IMP(a_out_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 3))

    // a stalled result word stays offered
    `DTEP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a stalled result word keeps its payload
    `DTEP_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_epoch_seconds) && $stable(o_format_error))

endmodule

bind datetime_text_to_epoch_seconds_top dtep_checker u_dtep_checker (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: modem clock text to epoch seconds
// Feeds clock strings one character word at a time and checks every result
// word against a cycle-free model of the converter kept in this bench. A short
// list of hand-picked strings comes first, then random strings across several
// reference offsets, with random gaps on the character side and random stalls
// on the result side.
// ----------------------------------------------------------------------------
module tb;
    import dtep_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 10;    // result pipeline is 3 deep; leave slack
    localparam int PHASE_CHARS   = 155;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // one expected result word
    typedef struct packed {
        logic [31:0] epoch;
        logic        err;
    } stamp_t;

    // one hand-picked string; len < 20 abandons it part way
    typedef struct packed {
        logic [159:0] text;
        logic [5:0]   len;
        logic         rs;
        logic         typed;
        stamp_t       fixed;
    } row_t;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic [7:0]              i_symbol    = 8'h00;
    logic                    i_restart   = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [31:0]             o_epoch_seconds;
    logic                    o_format_error;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic signed [CFG_W-1:0] i_cfg_data  = '0;

    datetime_text_to_epoch_seconds_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_symbol        (i_symbol),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_epoch_seconds (o_epoch_seconds),
        .o_format_error  (o_format_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    stamp_t      stamps_due[$];     // results owed by the block, oldest first
    row_t        plan_rows[$];
    logic [7:0]  text_buf [0:19];   // random string under construction
    stamp_t      want;
    int          fails        = 0;
    int          chars_sent   = 0;
    int          cycles       = 0;
    int          in_idle_pct  = 6;
    int          out_idle_pct = 6;
    logic        prev_cut     = 1'b1;

    // converter model: position, two-digit fields, sign, error, offset
    logic [4:0]  txt_pos;
    logic [6:0]  f_year, f_month, f_day, f_hour, f_min, f_sec, f_zone;
    logic        zone_neg;
    logic        bad_seen;
    logic [31:0] offset_now;

    // ------------------------------------------------------------------------
    // Converter model
    // ------------------------------------------------------------------------
    function automatic logic [6:0] next_two(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] w;
        w = {4'd0, acc} * 11'd10 + {7'd0, d};
        return w[6:0];
    endfunction

    // days from Jan 1 to the first of month m; 13 means a whole year
    function automatic logic [31:0] days_ahead(input logic [3:0] m);
        case (m)
            4'd2:    return 32'd31;
            4'd3:    return 32'd59;
            4'd4:    return 32'd90;
            4'd5:    return 32'd120;
            4'd6:    return 32'd151;
            4'd7:    return 32'd181;
            4'd8:    return 32'd212;
            4'd9:    return 32'd243;
            4'd10:   return 32'd273;
            4'd11:   return 32'd304;
            4'd12:   return 32'd334;
            4'd13:   return 32'd365;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] epoch_of_fields();
        logic [31:0] days;
        logic [31:0] total;
        logic [3:0]  mon_ix;
        mon_ix = (f_month > 7'd13) ? MONTH_CLAMP : f_month[3:0];
        days = 32'd365 * ({25'd0, f_year} + 32'd30) + ({25'd0, f_year} + 32'd31) / 32'd4;
        days = days + days_ahead(mon_ix);
        // leap day only counts once February is behind us
        if (f_year[1:0] == 2'b00 && mon_ix > MONTH_FEB)
            days = days + 32'd1;
        // day zero lands on the last day of the month before
        days  = days + {25'd0, f_day} - 32'd1;
        total = days * SECS_PER_DAY + {25'd0, f_hour} * SECS_PER_HOUR
              + {25'd0, f_min} * SECS_PER_MINUTE + {25'd0, f_sec};
        total = total + offset_now;
        if (zone_neg)
            total = total + SECS_PER_ZONE * {25'd0, f_zone};
        else
            total = total - SECS_PER_ZONE * {25'd0, f_zone};
        return total;
    endfunction

    task automatic clear_fields();
        f_year = '0; f_month = '0; f_day = '0; f_hour = '0;
        f_min = '0; f_sec = '0; f_zone = '0;
        zone_neg = 1'b0;
        bad_seen = 1'b0;
    endtask

    // advance the model by one accepted character word
    task automatic model_char(input logic [7:0] sym, input logic rs,
                              output logic got, output stamp_t s);
        logic [4:0] p;
        logic [3:0] dv;
        logic       bad;
        got = 1'b0;
        s   = '0;
        if (rs)
            txt_pos = '0;
        p = txt_pos;
        if (p > POS_LAST)
            p = '0;
        if (p == 5'd0)
            clear_fields();
        bad = !(sym >= CHAR_ZERO && sym <= CHAR_NINE);
        dv  = bad ? 4'd0 : sym[3:0];
        case (p)
            POS_YEAR_HI, POS_YEAR_LO: begin
                f_year = next_two(f_year, dv);
                bad_seen = bad_seen | bad;
            end
            POS_MONTH_HI, POS_MONTH_LO: begin
                f_month = next_two(f_month, dv);
                bad_seen = bad_seen | bad;
            end
            POS_DAY_HI, POS_DAY_LO: begin
                f_day = next_two(f_day, dv);
                bad_seen = bad_seen | bad;
            end
            POS_HOUR_HI, POS_HOUR_LO: begin
                f_hour = next_two(f_hour, dv);
                bad_seen = bad_seen | bad;
            end
            POS_MINUTE_HI, POS_MINUTE_LO: begin
                f_min = next_two(f_min, dv);
                bad_seen = bad_seen | bad;
            end
            POS_SECOND_HI, POS_SECOND_LO: begin
                f_sec = next_two(f_sec, dv);
                bad_seen = bad_seen | bad;
            end
            POS_SIGN: begin
                zone_neg = (sym == CHAR_MINUS);
            end
            POS_ZONE_HI, POS_ZONE_LO: begin
                f_zone = next_two(f_zone, dv);
                bad_seen = bad_seen | bad;
            end
            default: begin
            end
        endcase
        if (p == POS_LAST) begin
            got       = 1'b1;
            s.epoch   = epoch_of_fields();
            s.err     = bad_seen || (f_month > MONTH_MAX);
            txt_pos   = '0;
        end else begin
            txt_pos = p + 5'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------------
    // Offer one character word. Valid is only dropped while idling, so back to
    // back words never see valid lowered and raised in the same step.
    task automatic push_char(input logic [7:0] sym, input logic rs,
                             input logic use_fixed, input stamp_t fixed);
        logic   got;
        stamp_t s;
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        i_restart  <= rs;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // the word was taken at this edge
        model_char(sym, rs, got, s);
        if (got)
            stamps_due.push_back(use_fixed ? fixed : s);
        chars_sent++;
    endtask

    // Drop valid and hold off until every owed result has come out, then let
    // the pipeline run dry.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (stamps_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the reference offset; only called with the block idle.
    task automatic write_offset(input logic signed [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        offset_now  = {{(32-CFG_W){v[CFG_W-1]}}, v};
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [159:0] text, input int len, input logic rs,
                           input logic typed, input logic [31:0] epoch, input logic err);
        row_t r;
        r.text        = text;
        r.len         = 6'(len);
        r.rs          = rs;
        r.typed       = typed;
        r.fixed.epoch = epoch;
        r.fixed.err   = err;
        plan_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Random strings
    // ------------------------------------------------------------------------
    function automatic logic is_sep(input int k);
        return k == POS_YEAR_LO + 1 || k == POS_MONTH_LO + 1 || k == POS_DAY_LO + 1
            || k == POS_HOUR_LO + 1 || k == POS_MINUTE_LO + 1;
    endfunction

    function automatic logic [7:0] sep_char(input int k);
        if (k == POS_DAY_LO + 1)
            return CHAR_COMMA;
        if (k == POS_HOUR_LO + 1 || k == POS_MINUTE_LO + 1)
            return CHAR_COLON;
        return CHAR_SLASH;
    endfunction

    // mostly a plausible value, now and then anything two digits can hold
    function automatic int pick_two(input int usual);
        return ($urandom_range(99) < 90) ? $urandom_range(usual) : $urandom_range(99);
    endfunction

    task automatic put_pair(input t_pos p, input int v);
        text_buf[p]     = 8'(CHAR_ZERO + v / 10);
        text_buf[p + 1] = 8'(CHAR_ZERO + v % 10);
    endtask

    task automatic send_random_string();
        int   k;
        int   r;
        int   cut;
        logic rs0;
        put_pair(POS_YEAR_HI, $urandom_range(99));
        r = $urandom_range(99);
        put_pair(POS_MONTH_HI, (r < 80) ? $urandom_range(12, 1) :
                               (r < 88) ? 0 : $urandom_range(99, 13));
        put_pair(POS_DAY_HI, pick_two(31));
        put_pair(POS_HOUR_HI, pick_two(23));
        put_pair(POS_MINUTE_HI, pick_two(59));
        put_pair(POS_SECOND_HI, pick_two(59));
        put_pair(POS_ZONE_HI, pick_two(56));
        for (k = 0; k < 20; k++) begin
            if (is_sep(k))
                text_buf[k] = ($urandom_range(99) < 70) ? sep_char(k)
                                                        : 8'($urandom_range(255));
        end
        r = $urandom_range(99);
        text_buf[POS_SIGN] = (r < 45) ? CHAR_PLUS : (r < 90) ? CHAR_MINUS
                                                             : 8'($urandom_range(255));
        // spoil one digit now and then
        if ($urandom_range(99) < 10) begin
            do
                k = $urandom_range(19);
            while (is_sep(k) || k == POS_SIGN);
            text_buf[k] = 8'($urandom_range(255));
        end
        // abandon a few strings part way
        cut = ($urandom_range(99) < 8) ? $urandom_range(19, 1) : 20;
        rs0 = prev_cut ? 1'b1 : ($urandom_range(99) < 70);
        for (k = 0; k < cut; k++)
            push_char(text_buf[k], (k == 0) ? rs0 : 1'b0, 1'b0, '0);
        prev_cut = (cut != 20);
    endtask

    task automatic send_noise();
        int n;
        int k;
        n = $urandom_range(8, 1);
        for (k = 0; k < n; k++)
            push_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
        prev_cut = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random, compare each word with the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= !(out_idle_pct != 0 && $urandom_range(99) < out_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stamps_due.size() == 0) begin
                $error("unexpected result word: epoch_seconds %0d, format_error %0d",
                       o_epoch_seconds, o_format_error);
                fails++;
            end else begin
                want = stamps_due.pop_front();
                if (o_epoch_seconds !== want.epoch) begin
                    $error("epoch_seconds: expected %0d, actual %0d",
                           want.epoch, o_epoch_seconds);
                    fails++;
                end
                if (o_format_error !== want.err) begin
                    $error("format_error: expected %0d, actual %0d",
                           want.err, o_format_error);
                    fails++;
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int   i;
        int   k;
        int   ph;
        int   quota;
        row_t row;

        txt_pos    = '0;
        clear_fields();
        offset_now = {{(32-CFG_W){REF_OFFSET_RESET[CFG_W-1]}}, REF_OFFSET_RESET};

        // hold reset at the start, then release it once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Hand-picked strings at the reset offset. Earliest and latest dates,
        // month 13, a non-digit, zero month and day, leap days, full zones,
        // odd separators and sign, an abandoned string, a restart, 0xFF bytes.
        add_row("00/01/01,00:00:00+00", 20, 1'b1, 1'b1, 32'd946704600, 1'b0);
        add_row("99/12/31,23:59:59+00", 20, 1'b0, 1'b1, 32'd4102464599, 1'b0);
        add_row("00/13/01,00:00:00+00", 20, 1'b1, 1'b1, 32'd978327000, 1'b1);
        add_row("0a/01/01,00:00:00+00", 20, 1'b0, 1'b1, 32'd946704600, 1'b1);
        add_row("00/00/00,00:00:00+00", 20, 1'b1, 1'b0, 32'd0, 1'b0);
        add_row("04/02/29,00:00:00+99", 20, 1'b0, 1'b0, 32'd0, 1'b0);
        add_row("04/03/01,12:30:45-99", 20, 1'b0, 1'b0, 32'd0, 1'b0);
        add_row("99/99/99,99:99:99-99", 20, 1'b1, 1'b0, 32'd0, 1'b0);
        add_row("23x05y17z08w15v30*22", 20, 1'b0, 1'b0, 32'd0, 1'b0);
        add_row("12/06/15,10:44:00+20", 12, 1'b1, 1'b0, 32'd0, 1'b0);
        add_row("12/06/15,10:44:00+20", 20, 1'b1, 1'b0, 32'd0, 1'b0);
        add_row("9\377/12/31,23:59:59\37705", 20, 1'b0, 1'b0, 32'd0, 1'b0);
        add_row("12/06/15,10:44:00+20", 7, 1'b0, 1'b0, 32'd0, 1'b0);
        add_row("ab/cd/ef,gh:ij:kl-mn", 20, 1'b1, 1'b0, 32'd0, 1'b0);
        add_row("00/01/01,00:00:00+00", 20, 1'b0, 1'b1, 32'd946704600, 1'b0);

        for (i = 0; i < plan_rows.size(); i++) begin
            row = plan_rows[i];
            for (k = 0; k < row.len; k++)
                push_char(row.text[8*(19-k) +: 8], (k == 0) ? row.rs : 1'b0,
                          row.typed, row.fixed);
        end
        // hold the sender until every owed word is out
        settle();

        // Random strings across offsets: zero, both extremes, the reset value
        // written back, and random values; one phase runs with no idling.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       write_offset(18'sd0);
                1:       write_offset(18'sd86400);
                2:       write_offset(-18'sd86400);
                4:       write_offset(REF_OFFSET_RESET);
                default: write_offset(CFG_W'(int'($urandom_range(172800)) - 86400));
            endcase
            in_idle_pct  = (ph == 3) ? 0 : 6;
            out_idle_pct = (ph == 3) ? 0 : 6;
            quota = chars_sent + PHASE_CHARS;
            while (chars_sent < quota) begin
                if ($urandom_range(99) < 6)
                    send_noise();
                else
                    send_random_string();
            end
            settle();
        end

        if (fails == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
